@@ src/bbc_pkg.sv @@
// shared types and fixed field widths of the bootstrap bag counter
`timescale 1ns / 1ps
`default_nettype none

package bbc_pkg;

  // fixed widths of the item fields
  localparam int ROW_FW    = 16;
  localparam int MULT_FW   = 16;
  localparam int INDEX_FW  = 17;
  localparam int WORD_FW   = 32;
  localparam int SLOT_FW   = 11;
  localparam int ROWS_CFGW = 17;

  // item actions
  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_SCAN = 1'b1;

  // control states, one-hot
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  // one result item
  typedef struct packed {
    logic [ROW_FW-1:0]   row_out;
    logic [MULT_FW-1:0]  multiplicity;
    logic                in_bag;
    logic [INDEX_FW-1:0] sample_index;
    logic [INDEX_FW-1:0] bag_count;
    logic [WORD_FW-1:0]  bag_word;
    logic                word_valid;
    logic [SLOT_FW-1:0]  slot;
    logic                scan_done;
    logic                row_error;
  } out_item_t;

endpackage

`default_nettype wire

@@ src/bbc_if.sv @@
// valid/ready channel interfaces for input and result items
`timescale 1ns / 1ps
`default_nettype none

interface bbc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [bbc_pkg::ROW_FW-1:0] row;

  modport source (output valid, output action, output row, input ready);
  modport sink   (input valid, input action, input row, output ready);
endinterface

interface bbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [bbc_pkg::ROW_FW-1:0]   row_out;
  logic [bbc_pkg::MULT_FW-1:0]  multiplicity;
  logic                         in_bag;
  logic [bbc_pkg::INDEX_FW-1:0] sample_index;
  logic [bbc_pkg::INDEX_FW-1:0] bag_count;
  logic [bbc_pkg::WORD_FW-1:0]  bag_word;
  logic                         word_valid;
  logic [bbc_pkg::SLOT_FW-1:0]  slot;
  logic                         scan_done;
  logic                         row_error;

  modport source (output valid, output row_out, output multiplicity, output in_bag,
                  output sample_index, output bag_count, output bag_word,
                  output word_valid, output slot, output scan_done, output row_error,
                  input ready);
  modport sink   (input valid, input row_out, input multiplicity, input in_bag,
                  input sample_index, input bag_count, input bag_word,
                  input word_valid, input slot, input scan_done, input row_error,
                  output ready);
endinterface

`default_nettype wire

@@ src/bbc_count_mem.sv @@
// per-row sample count memory, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bbc_count_mem #(
  parameter int DEPTH = 65536,
  parameter int DW    = 16
) (
  input  wire                     clk,
  input  wire                     rd_en,
  input  wire [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]           rd_data,
  input  wire                     wr_en,
  input  wire [$clog2(DEPTH)-1:0] wr_addr,
  input  wire [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ src/bbc_bag_state.sv @@
// bag bookkeeping: distinct rows, scan position, slot packing and count update
`timescale 1ns / 1ps
`default_nettype none

module bbc_bag_state #(
  parameter int MAX_ROWS    = 65536,
  parameter int SLOT_BITS   = 32,
  parameter int COUNT_WIDTH = 16,
  parameter int NW          = 17
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire [NW-1:0]               rows_n,
  input  wire                        act,
  input  wire [bbc_pkg::ROW_FW-1:0]  row,
  input  wire [COUNT_WIDTH-1:0]      rd_data,
  input  wire                        commit,
  output logic [$clog2(MAX_ROWS)-1:0] scan_addr,
  output logic                       wr_en,
  output logic [$clog2(MAX_ROWS)-1:0] wr_addr,
  output logic [COUNT_WIDTH-1:0]     wr_data,
  output bbc_pkg::out_item_t         result
);

  localparam int AW   = $clog2(MAX_ROWS);
  localparam int PW   = (SLOT_BITS > 1) ? $clog2(SLOT_BITS) : 1;
  localparam int MW   = (COUNT_WIDTH > bbc_pkg::MULT_FW) ? COUNT_WIDTH : bbc_pkg::MULT_FW;
  localparam int BW   = (SLOT_BITS > bbc_pkg::WORD_FW) ? SLOT_BITS : bbc_pkg::WORD_FW;
  localparam int IW   = bbc_pkg::INDEX_FW;
  localparam logic [COUNT_WIDTH-1:0] CMAX = {COUNT_WIDTH{1'b1}};

  logic [IW-1:0]        distinct_r, distinct_nxt;
  logic [IW-1:0]        nsi_r, nsi_nxt;
  logic [NW-1:0]        scan_row_r, scan_row_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic [NW-1:0]        slot_r, slot_nxt;
  logic [SLOT_BITS-1:0] acc_r, acc_nxt;

  logic                 wrap;
  logic [NW-1:0]        r_cur;
  logic [IW-1:0]        nsi_cur;
  logic [PW-1:0]        pos_cur;
  logic [NW-1:0]        slot_cur;
  logic [SLOT_BITS-1:0] acc_cur, acc_new;
  logic                 c_nz, pos_last, last, word_out;
  logic [NW:0]          r_plus;
  logic [NW-1:0]        row_nw;
  logic                 row_err;
  logic [COUNT_WIDTH-1:0] c_inc;
  logic [MW-1:0]        mult_x;
  logic [BW-1:0]        word_x;

  // scan position, restarting when it has run past the rows in use
  always_comb begin
    wrap     = (scan_row_r >= rows_n);
    r_cur    = wrap ? '0 : scan_row_r;
    nsi_cur  = wrap ? '0 : nsi_r;
    pos_cur  = wrap ? '0 : pos_r;
    slot_cur = wrap ? '0 : slot_r;
    acc_cur  = wrap ? '0 : acc_r;
  end

  assign scan_addr = r_cur[AW-1:0];

  // scan bookkeeping
  always_comb begin
    c_nz     = (rd_data != '0);
    pos_last = (pos_cur == PW'(SLOT_BITS - 1));
    acc_new  = acc_cur | (c_nz ? (SLOT_BITS'(1) << pos_cur) : '0);
    r_plus   = {1'b0, r_cur} + (NW + 1)'(1);
    last     = (r_plus >= {1'b0, rows_n});
    word_out = last || pos_last;
  end

  // add bookkeeping
  always_comb begin
    row_nw  = NW'(row);
    row_err = (row_nw >= rows_n);
    c_inc   = (rd_data == CMAX) ? rd_data : rd_data + COUNT_WIDTH'(1);
  end

  // result item, next state and count write-back
  always_comb begin
    distinct_nxt = distinct_r;
    nsi_nxt      = nsi_r;
    scan_row_nxt = scan_row_r;
    pos_nxt      = pos_r;
    slot_nxt     = slot_r;
    acc_nxt      = acc_r;
    wr_en        = 1'b0;
    wr_addr      = r_cur[AW-1:0];
    wr_data      = '0;
    mult_x       = '0;
    word_x       = '0;
    result       = '0;

    if (act == bbc_pkg::ACT_SCAN) begin
      mult_x              = MW'(rd_data);
      word_x              = BW'(acc_new);
      result.row_out      = r_cur[bbc_pkg::ROW_FW-1:0];
      result.multiplicity = mult_x[bbc_pkg::MULT_FW-1:0];
      result.in_bag       = c_nz;
      result.sample_index = c_nz ? nsi_cur : distinct_r;
      result.bag_count    = distinct_r;
      result.word_valid   = word_out;
      result.bag_word     = word_out ? word_x[bbc_pkg::WORD_FW-1:0] : '0;
      result.slot         = word_out ? slot_cur[bbc_pkg::SLOT_FW-1:0] : '0;
      result.scan_done    = last;
      wr_en               = commit;
      if (last) begin
        distinct_nxt = '0;
        nsi_nxt      = '0;
        scan_row_nxt = '0;
        pos_nxt      = '0;
        slot_nxt     = '0;
        acc_nxt      = '0;
      end else begin
        nsi_nxt      = c_nz ? nsi_cur + IW'(1) : nsi_cur;
        scan_row_nxt = r_plus[NW-1:0];
        pos_nxt      = pos_last ? '0 : pos_cur + PW'(1);
        slot_nxt     = pos_last ? slot_cur + NW'(1) : slot_cur;
        acc_nxt      = word_out ? '0 : acc_new;
      end
    end else begin
      result.row_out   = row;
      result.row_error = row_err;
      if (row_err) begin
        result.bag_count = distinct_r;
      end else begin
        distinct_nxt        = c_nz ? distinct_r : distinct_r + IW'(1);
        mult_x              = MW'(c_inc);
        result.multiplicity = mult_x[bbc_pkg::MULT_FW-1:0];
        result.in_bag       = 1'b1;
        result.bag_count    = distinct_nxt;
        wr_en               = commit;
        wr_addr             = row_nw[AW-1:0];
        wr_data             = c_inc;
      end
    end
  end

  // bag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      distinct_r <= '0;
      nsi_r      <= '0;
      scan_row_r <= '0;
      pos_r      <= '0;
      slot_r     <= '0;
      acc_r      <= '0;
    end else if (commit) begin
      distinct_r <= distinct_nxt;
      nsi_r      <= nsi_nxt;
      scan_row_r <= scan_row_nxt;
      pos_r      <= pos_nxt;
      slot_r     <= slot_nxt;
      acc_r      <= acc_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/bootstrap_bag_counter.sv @@
// top level of the bootstrap bag counter
`timescale 1ns / 1ps
`default_nettype none

// Builds the bootstrap bag of one tree from a count memory of MAX_ROWS entries.
// Add items bump a row's saturating count or flag a row out of range; scan
// items visit rows in order, report multiplicity, in-bag flag and dense sample
// index, clear the count and emit a packed bag word at each slot end and at the
// frame end. Every item gives exactly one result. The count is read from the
// memory at the accepting edge and written back, modified, when the item commits
// once the output register is free, so no two items touch the memory at once.
// A result waits in an output register; the next item is accepted once it has
// moved into that register. After reset the memory is cleared one entry a cycle,
// during which no item is accepted; configuration writes are taken throughout.
module bootstrap_bag_counter #(
  parameter int MAX_ROWS    = 65536,
  parameter int SLOT_BITS   = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            cfg_we,
  input  wire [bbc_pkg::ROWS_CFGW-1:0]   cfg_wdata,
  bbc_in_if.sink                         in_ch,
  bbc_out_if.source                      out_ch
);

  localparam int AW  = $clog2(MAX_ROWS);
  localparam int NW0 = $clog2(MAX_ROWS + 1);
  localparam int NW  = (NW0 > bbc_pkg::ROWS_CFGW) ? NW0 : bbc_pkg::ROWS_CFGW;

  bbc_pkg::state_t    state_r, state_nxt;
  logic [AW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [bbc_pkg::ROWS_CFGW-1:0] rows_in_use_r;
  logic               act_r;
  logic [bbc_pkg::ROW_FW-1:0] row_r;
  logic               out_valid_r, out_valid_nxt;
  bbc_pkg::out_item_t out_r;
  bbc_pkg::out_item_t result;

  logic [NW-1:0]      rows_ext, rows_n;
  logic [NW-1:0]      in_row_nw;
  logic               accept, commit;
  logic [AW-1:0]      scan_addr, rd_addr, upd_addr, mem_waddr;
  logic               upd_we, mem_we;
  logic [COUNT_WIDTH-1:0] rd_data, upd_data, mem_wdata;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use_r <= bbc_pkg::ROWS_CFGW'(65536);
    end else if (cfg_we) begin
      rows_in_use_r <= cfg_wdata;
    end
  end

  // effective row count, clamped to one .. MAX_ROWS
  always_comb begin
    rows_ext = NW'(rows_in_use_r);
    if (rows_ext == '0) begin
      rows_n = NW'(1);
    end else if (rows_ext > NW'(MAX_ROWS)) begin
      rows_n = NW'(MAX_ROWS);
    end else begin
      rows_n = rows_ext;
    end
  end

  // handshakes
  assign in_ch.ready = (state_r == bbc_pkg::ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign commit      = (state_r == bbc_pkg::ST_EXEC) && (!out_valid_r || out_ch.ready);

  // read address of the accepted item
  assign in_row_nw = NW'(in_ch.row);
  assign rd_addr   = (in_ch.action == bbc_pkg::ACT_SCAN) ? scan_addr : in_row_nw[AW-1:0];

  // control state machine
  always_comb begin
    state_nxt   = state_r;
    clr_idx_nxt = clr_idx_r;
    case (state_r)
      bbc_pkg::ST_CLEAR: begin
        clr_idx_nxt = clr_idx_r + AW'(1);
        if (clr_idx_r == AW'(MAX_ROWS - 1)) begin
          state_nxt = bbc_pkg::ST_IDLE;
        end
      end
      bbc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = bbc_pkg::ST_EXEC;
        end
      end
      bbc_pkg::ST_EXEC: begin
        if (commit) begin
          state_nxt = bbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bbc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= bbc_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // item register
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_ch.action;
      row_r <= in_ch.row;
    end
  end

  // memory write port: clearing sweep or count write-back
  always_comb begin
    if (state_r == bbc_pkg::ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_idx_r;
      mem_wdata = '0;
    end else begin
      mem_we    = upd_we;
      mem_waddr = upd_addr;
      mem_wdata = upd_data;
    end
  end

  bbc_count_mem #(
    .DEPTH (MAX_ROWS),
    .DW    (COUNT_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata)
  );

  bbc_bag_state #(
    .MAX_ROWS    (MAX_ROWS),
    .SLOT_BITS   (SLOT_BITS),
    .COUNT_WIDTH (COUNT_WIDTH),
    .NW          (NW)
  ) u_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .rows_n    (rows_n),
    .act       (act_r),
    .row       (row_r),
    .rd_data   (rd_data),
    .commit    (commit),
    .scan_addr (scan_addr),
    .wr_en     (upd_we),
    .wr_addr   (upd_addr),
    .wr_data   (upd_data),
    .result    (result)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_r <= result;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.row_out      = out_r.row_out;
  assign out_ch.multiplicity = out_r.multiplicity;
  assign out_ch.in_bag       = out_r.in_bag;
  assign out_ch.sample_index = out_r.sample_index;
  assign out_ch.bag_count    = out_r.bag_count;
  assign out_ch.bag_word     = out_r.bag_word;
  assign out_ch.word_valid   = out_r.word_valid;
  assign out_ch.slot         = out_r.slot;
  assign out_ch.scan_done    = out_r.scan_done;
  assign out_ch.row_error    = out_r.row_error;

  // no item enters while the memory is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bbc_pkg::ST_CLEAR) |-> !accept)
    else $error("item accepted during memory clear");

  // an accepted item is worked on in the next cycle
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == bbc_pkg::ST_EXEC))
    else $error("accepted item not in execution");

  // a committed item shows up on the result channel
  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed item missing from output register");

  // only the clearing sweep or a committing item writes the count memory
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> ((state_r == bbc_pkg::ST_CLEAR) || commit))
    else $error("stray count memory write");

endmodule

`default_nettype wire

@@ bench/bag_board_pkg.sv @@
// scoreboard class that predicts and checks bag counter result items
`timescale 1ns / 1ps

package bag_board_pkg;
  import bbc_pkg::*;

  localparam int unsigned ROW_SPAN  = 65536;
  localparam int unsigned SLOT_SPAN = 32;
  localparam logic [MULT_FW-1:0] COUNT_TOP = 16'hFFFF;
  localparam int REPORT_CAP = 60;

  class bag_board;
    // predicted block state
    bit [MULT_FW-1:0]   counts [ROW_SPAN];
    bit [ROWS_CFGW-1:0] rows_cfg;
    bit [INDEX_FW-1:0]  distinct;
    bit [INDEX_FW-1:0]  next_index;
    bit [INDEX_FW-1:0]  scan_row;
    bit [WORD_FW-1:0]   acc;
    out_item_t          expected_q[$];
    int                 errors;
    int                 checked;

    function new();
      rows_cfg   = 17'h10000;
      distinct   = '0;
      next_index = '0;
      scan_row   = '0;
      acc        = '0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_rows(bit [ROWS_CFGW-1:0] v);
      rows_cfg = v;
    endfunction

    // zero acts as one row, anything above the memory size as the full memory
    function int unsigned rows_eff();
      int unsigned n;
      n = rows_cfg;
      if (n == 0) n = 1;
      if (n > ROW_SPAN) n = ROW_SPAN;
      return n;
    endfunction

    // scan items still needed to reach the end of the frame
    function int unsigned rows_left();
      int unsigned n;
      n = rows_eff();
      return (scan_row >= n) ? n : n - scan_row;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_scan();
      scan_row   = '0;
      next_index = '0;
      acc        = '0;
    endfunction

    // work out the result of one accepted item and queue it
    function void note_item(logic action, logic [ROW_FW-1:0] row);
      out_item_t        e;
      int unsigned      n;
      int unsigned      r;
      int unsigned      pos;
      bit [MULT_FW-1:0] c;
      e = '0;
      n = rows_eff();
      if (action == ACT_ADD) begin
        e.row_out = row;
        if (row >= n) begin
          e.bag_count = distinct;
          e.row_error = 1'b1;
        end else begin
          c = counts[row];
          if (c == 0) distinct++;
          if (c != COUNT_TOP) c++;
          counts[row]    = c;
          e.multiplicity = c;
          e.in_bag       = 1'b1;
          e.bag_count    = distinct;
        end
      end else begin
        // register lowered below the scan position restarts the scan
        if (scan_row >= n) clear_scan();
        r = scan_row;
        c = counts[r];
        counts[r] = '0;
        pos = r % SLOT_SPAN;
        e.row_out      = r[ROW_FW-1:0];
        e.multiplicity = c;
        e.bag_count    = distinct;
        if (c != 0) begin
          e.in_bag       = 1'b1;
          e.sample_index = next_index;
          next_index++;
          acc[pos] = 1'b1;
        end else begin
          e.sample_index = distinct;
        end
        // slot word goes out at the slot end or the frame end
        if (r + 1 >= n || pos == SLOT_SPAN - 1) begin
          e.bag_word   = acc;
          e.word_valid = 1'b1;
          e.slot       = SLOT_FW'(r / SLOT_SPAN);
          acc          = '0;
        end
        if (r + 1 >= n) begin
          e.scan_done = 1'b1;
          clear_scan();
          distinct = '0;
        end else begin
          scan_row = INDEX_FW'(r + 1);
        end
      end
      expected_q.push_back(e);
    endfunction

    // print capped so a broken block cannot flood the log
    task report(string msg);
      errors++;
      if (errors <= REPORT_CAP) $display("bag check: %s", msg);
    endtask

    task cmp(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report($sformatf("result %0d %s got %0h want %0h", checked, what, got, want));
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing pending", checked));
        return;
      end
      want = expected_q.pop_front();
      cmp("row_out", got.row_out, want.row_out);
      cmp("multiplicity", got.multiplicity, want.multiplicity);
      cmp("in_bag", got.in_bag, want.in_bag);
      cmp("sample_index", got.sample_index, want.sample_index);
      cmp("bag_count", got.bag_count, want.bag_count);
      cmp("bag_word", got.bag_word, want.bag_word);
      cmp("word_valid", got.word_valid, want.word_valid);
      cmp("slot", got.slot, want.slot);
      cmp("scan_done", got.scan_done, want.scan_done);
      cmp("row_error", got.row_error, want.row_error);
    endtask
  endclass

endpackage

@@ bench/tb_top.sv @@
// top of the bag counter bench: stimulus, stalls, monitor and watchdog
`timescale 1ns / 1ps

module tb_top;
  import bbc_pkg::*;
  import bag_board_pkg::*;

  localparam int unsigned QUIET_LIMIT = 300000;
  localparam int RANDOM_STOP = 500;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [ROWS_CFGW-1:0] cfg_wdata;

  bbc_in_if  in_ch ();
  bbc_out_if out_ch ();

  bag_board    sb;
  out_item_t   seen;
  int          burst_left;
  int          items_sent;
  bit          hold_req;
  int unsigned quiet = 0;

  bootstrap_bag_counter uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hand one item to the block and wait for it to be taken
  task send_item(input logic act, input logic [ROW_FW-1:0] r);
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.row    <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // sender works in bursts with random gaps between them
  task offer(input logic act, input logic [ROW_FW-1:0] r);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 10);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    items_sent++;
    send_item(act, r);
  endtask

  // stop sending and wait for every pending result
  task quiesce();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task write_rows(input logic [ROWS_CFGW-1:0] v);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    sb.set_rows(v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // scan items, with an occasional add slipped in when noisy
  task run_scans(input int unsigned k, input bit noisy);
    for (int unsigned i = 0; i < k; i++) begin
      if (noisy && $urandom_range(0, 11) == 0) offer(ACT_ADD, ROW_FW'($urandom));
      offer(ACT_SCAN, ROW_FW'($urandom));
    end
  endtask

  // one bag: pick a frame size, load samples, then scan to the end or break off
  task random_bag();
    int unsigned n;
    int unsigned k;
    int unsigned left;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) n = ROW_SPAN;
    else if (pick == 1) n = $urandom_range(1, 300);
    else n = $urandom_range(1, 64);
    write_rows(ROWS_CFGW'(n));
    k = (n > 30) ? $urandom_range(0, 60) : $urandom_range(0, 2 * n);
    for (int unsigned i = 0; i < k; i++) begin
      case ($urandom_range(0, 15))
        0: offer(ACT_SCAN, ROW_FW'($urandom));
        1: offer(ACT_ADD, ROW_FW'($urandom));
        default: offer(ACT_ADD, ROW_FW'($urandom_range(0, n - 1)));
      endcase
    end
    quiesce();
    left = sb.rows_left();
    if (n == ROW_SPAN) left = $urandom_range(1, 40);
    else if ($urandom_range(0, 5) == 0) left = $urandom_range(0, left);
    run_scans(left, 1'b1);
  endtask

  // receiver stall pattern, with one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge clk);
          end
          3: begin
            out_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
          end
          default: begin
            for (int i = 0; i < 20; i++) begin
              out_ch.ready <= $urandom_range(0, 1);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  // results are checked before the input of the same edge is noted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        seen = '{out_ch.row_out, out_ch.multiplicity, out_ch.in_bag, out_ch.sample_index,
                 out_ch.bag_count, out_ch.bag_word, out_ch.word_valid, out_ch.slot,
                 out_ch.scan_done, out_ch.row_error};
        sb.check_result(seen);
      end
      if (in_ch.valid && in_ch.ready) sb.note_item(in_ch.action, in_ch.row);
    end
  end

  // watchdog on cycles without any item moving
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    sb = new();
    burst_left = 0;
    items_sent = 0;
    hold_req   = 1'b0;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_ADD;
    in_ch.row    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // zero register acts as a single row: repeat add, out of range rows, empty rescan
    write_rows(17'd0);
    offer(ACT_ADD, 16'd0);
    offer(ACT_ADD, 16'd0);
    offer(ACT_ADD, 16'd1);
    offer(ACT_ADD, 16'hFFFF);
    run_scans(2, 1'b0);

    // forty rows across two slots, last row and first row past the end
    write_rows(17'd40);
    offer(ACT_ADD, 16'd3);
    offer(ACT_ADD, 16'd31);
    offer(ACT_ADD, 16'd32);
    offer(ACT_ADD, 16'd39);
    offer(ACT_ADD, 16'd3);
    offer(ACT_ADD, 16'd40);
    run_scans(6, 1'b0);
    // add during a scan, then lower the register below the scan position
    offer(ACT_ADD, 16'd0);
    write_rows(17'd5);
    run_scans(5, 1'b0);

    // register above the memory size acts as the full memory
    write_rows(17'h1FFFF);
    offer(ACT_ADD, 16'hFFFF);
    offer(ACT_ADD, 16'h0000);

    // long receiver hold-off while the sender keeps offering, so the block fills
    hold_req = 1'b1;
    while (hold_req) @(posedge clk);
    repeat (6) offer(ACT_ADD, ROW_FW'($urandom));

    // random bags
    while (items_sent < RANDOM_STOP) random_bag();

    quiesce();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0) sb.report("expected results never arrived");
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
